[rtl/aos_pkg.sv]
// Shared types, constants and tables for the arctangent overdrive shaper.
package aos_pkg;

  localparam int APPROX_STEPS = 16;
  localparam int LOG_FRAC     = 28;
  localparam int TAYLOR_TERMS = 16;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 25;
  localparam int EXP_W    = 21;
  localparam int OUT_W    = 32;
  localparam int U_W      = 49;
  localparam int CORDIC_W = 52;
  localparam int ANGLE_W  = 33;
  localparam int A_W      = 31;
  localparam int L_W      = 34;
  localparam int T_W      = 40;
  localparam int TI_W     = 12;
  localparam int W_W      = 30;
  localparam int TERM_W   = 31;
  localparam int SUM_W    = 32;
  localparam int P_W      = 52;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // Register map index (paddr[3:2])
  localparam logic [1:0] REG_DRIVE  = 2'd0;
  localparam logic [1:0] REG_SHAPE  = 2'd1;
  localparam logic [1:0] REG_MAKEUP = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
  localparam logic [EXP_W-1:0]  EXP_ONE  = EXP_W'(65536);

  // Side information carried along with each request
  typedef struct packed {
    logic neg;
    logic zero;
  } side_t;

  // atan(2^-i) in Q0.30, rounded
  function automatic logic [29:0] atan_angle(input int i);
    logic [29:0] r;
    case (i)
      0:       r = 30'd843314857;
      1:       r = 30'd497837829;
      2:       r = 30'd263043837;
      3:       r = 30'd133525159;
      4:       r = 30'd67021687;
      5:       r = 30'd33543516;
      6:       r = 30'd16775851;
      7:       r = 30'd8388437;
      8:       r = 30'd4194283;
      9:       r = 30'd2097149;
      default: r = (i <= 30) ? 30'(31'd1 << (30 - i)) : '0;
    endcase
    return r;
  endfunction

  // floor(2^32 / n) for the Taylor divisors
  function automatic logic [32:0] recip_q32(input int n);
    logic [32:0] r;
    case (n)
      1:       r = 33'd4294967296;
      2:       r = 33'd2147483648;
      3:       r = 33'd1431655765;
      4:       r = 33'd1073741824;
      5:       r = 33'd858993459;
      6:       r = 33'd715827882;
      7:       r = 33'd613566756;
      8:       r = 33'd536870912;
      9:       r = 33'd477218588;
      10:      r = 33'd429496729;
      11:      r = 33'd390451572;
      12:      r = 33'd357913941;
      13:      r = 33'd330382099;
      14:      r = 33'd306783378;
      15:      r = 33'd286331153;
      16:      r = 33'd268435456;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/atan_overdrive_shaper.sv]
// Arctangent overdrive waveshaper: drive gain, CORDIC arctangent, power curve, makeup gain.
//
// Usage:
//   Input requests (in_valid, in_sample_in, Q1.23) are taken on any clock edge where
//   in_valid is high and in_stall is low. Each request yields one result request on
//   out_valid / out_sample_out (Q8.23, saturated), in the same order.
//   Gains and the shape exponent are set through the APB port at byte addresses
//   0 (drive_gain), 4 (shape_exponent) and 8 (makeup_gain); write them only while
//   no request is in flight. cfg_pready is always high; reads return the registers.
//   A request passes through 101 register stages from the accepting edge to out_valid:
//   one drive multiply, the CORDIC steps plus a clamp, 30 logarithm stages,
//   51 power stages (three per Taylor term), and two makeup stages. One request is
//   accepted every cycle while in_stall is low.
//   While out_valid is held by out_stall, the whole pipeline freezes and in_stall
//   rises in the same cycle; nothing is dropped or repeated.
//   Reset (synchronous, rst_n low) clears every valid bit and sets all three
//   registers to 1.0.
module atan_overdrive_shaper import aos_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_W-1:0]    out_sample_out,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [3:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [GAIN_W-1:0]     drive_gain_r;
  logic [EXP_W-1:0]      shape_exponent_r;
  logic [GAIN_W-1:0]     makeup_gain_r;
  logic                  cfg_wr;

  logic                  adv;

  // Drive stage
  logic                  neg;
  logic [SAMPLE_W-1:0]   mag;
  logic                  u_v_r;
  logic [U_W-1:0]        u_r;
  side_t                 u_s_r;

  logic                  a_v;
  logic [A_W-1:0]        a;
  side_t                 a_s;
  logic                  l_v;
  logic signed [L_W-1:0] l;
  side_t                 l_s;
  logic                  p_v;
  logic [P_W-1:0]        p;
  side_t                 p_s;

  // Makeup stage
  logic                  m_v_r;
  logic [53:0]           hi_r;
  logic [GAIN_W-1:0]     lo_r;
  side_t                 m_s_r;
  logic [47:0]           lo_prod;
  logic [54:0]           r;
  logic [OUT_W-1:0]      out_nxt;

  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_sample_out_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_gain_r     <= GAIN_ONE;
      shape_exponent_r <= EXP_ONE;
      makeup_gain_r    <= GAIN_ONE;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_DRIVE:  drive_gain_r     <= cfg_pwdata[GAIN_W-1:0];
        REG_SHAPE:  shape_exponent_r <= cfg_pwdata[EXP_W-1:0];
        REG_MAKEUP: makeup_gain_r    <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_DRIVE:  cfg_prdata = 32'(drive_gain_r);
      REG_SHAPE:  cfg_prdata = 32'(shape_exponent_r);
      REG_MAKEUP: cfg_prdata = 32'(makeup_gain_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Advance the whole pipeline unless the output is held
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Take the magnitude and apply the drive gain
  assign neg = in_sample_in[SAMPLE_W-1];
  assign mag = neg ? SAMPLE_W'(25'h100_0000 - 25'($unsigned(in_sample_in)))
                   : $unsigned(in_sample_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_v_r <= 1'b0;
    end else if (adv) begin
      u_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r        <= mag * drive_gain_r;
      u_s_r.neg  <= neg;
      u_s_r.zero <= (mag == '0) || (drive_gain_r == '0);
    end
  end

  aos_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (u_v_r),
    .in_u     (u_r),
    .in_side  (u_s_r),
    .out_v    (a_v),
    .out_a    (a),
    .out_side (a_s)
  );

  aos_log2 u_log2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (a_v),
    .in_a     (a),
    .in_side  (a_s),
    .out_v    (l_v),
    .out_l    (l),
    .out_side (l_s)
  );

  aos_pow u_pow (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .shape_exponent (shape_exponent_r),
    .in_v           (l_v),
    .in_l           (l),
    .in_side        (l_s),
    .out_v          (p_v),
    .out_p          (p),
    .out_side       (p_s)
  );

  // Split the makeup multiply into integer and fraction parts
  assign lo_prod = p[22:0] * makeup_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hi_r  <= p[P_W-1:23] * makeup_gain_r;
      lo_r  <= lo_prod[47:23];
      m_s_r <= p_s;
    end
  end

  // Sum, saturate and restore the sign
  assign r = 55'(hi_r) + 55'(lo_r);

  always_comb begin
    if (m_s_r.zero) begin
      out_nxt = '0;
    end else if (m_s_r.neg) begin
      out_nxt = (r >= 55'h8000_0000) ? 32'h8000_0000 : 32'(-r[31:0]);
    end else begin
      out_nxt = (r > 55'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_out_r <= out_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = $signed(out_sample_out_r);

endmodule

[rtl/aos_cordic.sv]
// Pipelined CORDIC vectoring unit: arctangent of the driven magnitude, one stage per step.
module aos_cordic import aos_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_v,
  input  logic [U_W-1:0]     in_u,
  input  side_t              in_side,
  output logic               out_v,
  output logic [A_W-1:0]     out_a,
  output side_t              out_side
);

  localparam int N = APPROX_STEPS;
  localparam logic signed [CORDIC_W-1:0] X_INIT = CORDIC_W'(40'h80_0000_0000);

  logic [N-1:0]                v_r;
  logic signed [CORDIC_W-1:0]  x_r [N];
  logic signed [CORDIC_W-1:0]  y_r [N];
  logic signed [ANGLE_W-1:0]   z_r [N];
  side_t                       s_r [N];

  logic                        a_v_r;
  logic [A_W-1:0]              a_r;
  side_t                       a_s_r;
  logic [A_W-1:0]              a_nxt;

  for (genvar i = 0; i < N; i++) begin : g_it
    logic signed [CORDIC_W-1:0] x_i, y_i, x_nxt, y_nxt;
    logic signed [ANGLE_W-1:0]  z_i, z_nxt, ang;
    logic                       v_i;
    side_t                      s_i;

    if (i == 0) begin : g_first
      assign x_i = X_INIT;
      assign y_i = $signed(CORDIC_W'(in_u));
      assign z_i = '0;
      assign v_i = in_v;
      assign s_i = in_side;
    end else begin : g_next
      assign x_i = x_r[i-1];
      assign y_i = y_r[i-1];
      assign z_i = z_r[i-1];
      assign v_i = v_r[i-1];
      assign s_i = s_r[i-1];
    end

    assign ang = $signed(ANGLE_W'(atan_angle(i)));

    // Rotate toward the x axis
    always_comb begin
      if (!y_i[CORDIC_W-1]) begin
        x_nxt = x_i + (y_i >>> i);
        y_nxt = y_i - (x_i >>> i);
        z_nxt = z_i + ang;
      end else begin
        x_nxt = x_i - (y_i >>> i);
        y_nxt = y_i + (x_i >>> i);
        z_nxt = z_i - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        s_r[i] <= s_i;
      end
    end
  end

  // Clamp the angle at zero and flag an empty result
  assign a_nxt = z_r[N-1][ANGLE_W-1] ? '0 : z_r[N-1][A_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r        <= a_nxt;
      a_s_r.neg  <= s_r[N-1].neg;
      a_s_r.zero <= s_r[N-1].zero | (a_nxt == '0);
    end
  end

  assign out_v    = a_v_r;
  assign out_a    = a_r;
  assign out_side = a_s_r;

endmodule

[rtl/aos_log2.sv]
// Pipelined base-two logarithm: normalize, then one squaring stage per fraction bit.
module aos_log2 import aos_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_v,
  input  logic [A_W-1:0]        in_a,
  input  side_t                 in_side,
  output logic                  out_v,
  output logic signed [L_W-1:0] out_l,
  output side_t                 out_side
);

  localparam int NF = LOG_FRAC;

  // Leading-one search stage
  logic                v0_r;
  logic [A_W-1:0]      a0_r;
  logic [4:0]          k0_r;
  side_t               s0_r;
  logic [4:0]          k_c;

  // Normalize stage
  logic                v1_r;
  logic [A_W-1:0]      m1_r;
  logic [4:0]          k1_r;
  side_t               s1_r;

  // Squaring stages
  logic [NF-1:0]       v_r;
  logic [A_W-1:0]      m_r [NF];
  logic [4:0]          k_r [NF];
  logic [NF-1:0]       f_r [NF];
  side_t               s_r [NF];

  logic signed [5:0]   kdiff;

  always_comb begin
    k_c = '0;
    for (int b = 0; b < A_W; b++) begin
      if (in_a[b]) k_c = 5'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_v;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r <= in_a;
      k0_r <= k_c;
      s0_r <= in_side;
      m1_r <= A_W'(a0_r << (5'd30 - k0_r));
      k1_r <= k0_r;
      s1_r <= s0_r;
    end
  end

  for (genvar j = 0; j < NF; j++) begin : g_sq
    logic [A_W-1:0]     m_i, m_nxt;
    logic [4:0]         k_i;
    logic [NF-1:0]      f_i, f_nxt;
    logic               v_i;
    side_t              s_i;
    logic [2*A_W-1:0]   sq;
    logic [A_W:0]       sq_hi;

    if (j == 0) begin : g_first
      assign m_i = m1_r;
      assign k_i = k1_r;
      assign f_i = '0;
      assign v_i = v1_r;
      assign s_i = s1_r;
    end else begin : g_next
      assign m_i = m_r[j-1];
      assign k_i = k_r[j-1];
      assign f_i = f_r[j-1];
      assign v_i = v_r[j-1];
      assign s_i = s_r[j-1];
    end

    // Square, truncate to Q1.30, renormalize when it reaches 2.0
    assign sq    = m_i * m_i;
    assign sq_hi = sq[2*A_W-1:30];

    always_comb begin
      if (sq_hi[A_W]) begin
        m_nxt = sq_hi[A_W:1];
        f_nxt = f_i | (NF'(1) << (NF - 1 - j));
      end else begin
        m_nxt = sq_hi[A_W-1:0];
        f_nxt = f_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[j] <= m_nxt;
        k_r[j] <= k_i;
        f_r[j] <= f_nxt;
        s_r[j] <= s_i;
      end
    end
  end

  // Integer part is k - 30, fraction bits below it
  assign kdiff    = $signed({1'b0, k_r[NF-1]}) - 6'sd30;
  assign out_l    = $signed({kdiff, f_r[NF-1]});
  assign out_v    = v_r[NF-1];
  assign out_side = s_r[NF-1];

endmodule

[rtl/aos_pow.sv]
// Pipelined exponent scaling and base-two power (Taylor series, one term per three stages).
module aos_pow import aos_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [EXP_W-1:0]      shape_exponent,
  input  logic                  in_v,
  input  logic signed [L_W-1:0] in_l,
  input  side_t                 in_side,
  output logic                  out_v,
  output logic [P_W-1:0]        out_p,
  output side_t                 out_side
);

  localparam int TT = TAYLOR_TERMS;

  typedef struct packed {
    logic [W_W-1:0]         w;
    logic [SUM_W-1:0]       sum;
    logic signed [TI_W-1:0] ti;
    side_t                  side;
  } carry_t;

  // Exponent multiply stage
  logic                       vt_r;
  logic signed [T_W-1:0]      t_r;
  side_t                      st_r;
  logic signed [L_W+EXP_W:0]  tprod;

  // Split and ln2 scale stage
  logic                       vw_r;
  carry_t                     cw_r;
  logic [LOG_FRAC+W_W-1:0]    wprod;

  // Taylor term stages
  logic [TT-1:0]       v1_r, v2_r, v3_r;
  carry_t              c1_r [TT];
  carry_t              c2_r [TT];
  carry_t              c3_r [TT];
  logic [TERM_W-1:0]   p1_r [TT];
  logic [TERM_W-1:0]   p2_r [TT];
  logic [TERM_W-1:0]   q2_r [TT];
  logic [TERM_W-1:0]   term_r [TT];

  // Final shift stage
  logic                vp_r;
  logic [P_W-1:0]      p_r;
  side_t               sp_r;
  logic [P_W-1:0]      p_nxt;
  logic [TI_W-1:0]     nt;
  carry_t              cf;

  assign tprod = in_l * $signed({1'b0, shape_exponent});
  assign wprod = t_r[LOG_FRAC-1:0] * LN2_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
      vw_r <= 1'b0;
    end else if (adv) begin
      vt_r <= in_v;
      vw_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r        <= T_W'(tprod >>> 16);
      st_r       <= in_side;
      cw_r.w     <= wprod[LOG_FRAC+W_W-1:LOG_FRAC];
      cw_r.sum   <= SUM_W'(32'h4000_0000);
      cw_r.ti    <= t_r[T_W-1:LOG_FRAC];
      cw_r.side  <= st_r;
    end
  end

  for (genvar k = 0; k < TT; k++) begin : g_term
    localparam logic [32:0] RECIP = recip_q32(k + 1);
    localparam logic [TERM_W-1:0] DIV = TERM_W'(k + 1);

    logic                 v_i;
    carry_t               c_i;
    logic [TERM_W-1:0]    term_i;
    logic [TERM_W+W_W-1:0] mprod;
    logic [TERM_W+32:0]   rprod;
    logic [TERM_W-1:0]    rem;
    logic [TERM_W-1:0]    q;

    if (k == 0) begin : g_first
      assign v_i    = vw_r;
      assign c_i    = cw_r;
      assign term_i = TERM_W'(32'h4000_0000);
    end else begin : g_next
      assign v_i    = v3_r[k-1];
      assign c_i    = c3_r[k-1];
      assign term_i = term_r[k-1];
    end

    // Multiply by w, then divide by the term index via reciprocal
    assign mprod = term_i * c_i.w;
    assign rprod = p1_r[k] * RECIP;
    assign rem   = p2_r[k] - TERM_W'(q2_r[k] * DIV);
    assign q     = (rem >= DIV) ? q2_r[k] + TERM_W'(1) : q2_r[k];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r[k] <= 1'b0;
        v2_r[k] <= 1'b0;
        v3_r[k] <= 1'b0;
      end else if (adv) begin
        v1_r[k] <= v_i;
        v2_r[k] <= v1_r[k];
        v3_r[k] <= v2_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p1_r[k]      <= mprod[TERM_W+W_W-1:30];
        c1_r[k]      <= c_i;
        p2_r[k]      <= p1_r[k];
        q2_r[k]      <= rprod[TERM_W+31:32];
        c2_r[k]      <= c1_r[k];
        term_r[k]    <= q;
        c3_r[k].w    <= c2_r[k].w;
        c3_r[k].ti   <= c2_r[k].ti;
        c3_r[k].side <= c2_r[k].side;
        c3_r[k].sum  <= c2_r[k].sum + SUM_W'(q);
      end
    end
  end

  // Apply the integer part of the exponent as a shift
  assign cf = c3_r[TT-1];
  assign nt = TI_W'(-cf.ti);

  always_comb begin
    if (!cf.ti[TI_W-1]) begin
      if (cf.ti > TI_W'(20)) begin
        p_nxt = P_W'(cf.sum) << 20;
      end else begin
        p_nxt = P_W'(cf.sum) << cf.ti[4:0];
      end
    end else if (nt >= TI_W'(40)) begin
      p_nxt = '0;
    end else begin
      p_nxt = P_W'(cf.sum) >> nt[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (adv) begin
      vp_r <= v3_r[TT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= p_nxt;
      sp_r <= cf.side;
    end
  end

  assign out_v    = vp_r;
  assign out_p    = p_r;
  assign out_side = sp_r;

endmodule

[rtl/aos_checker.sv]
// Port-level checker for the shaper, bound to the top level.
module aos_checker import aos_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [OUT_W-1:0]    out_sample_out
);

  // Held result request keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("result changed while stalled");

  // Input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind atan_overdrive_shaper aos_checker u_aos_checker (.*);

[test/atan_overdrive_shaper_tb.sv]
// Self-checking testbench for the arctangent overdrive shaper.
module atan_overdrive_shaper_tb;
  import aos_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_sample_out;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // register copies used by the shaper model
  logic [GAIN_W-1:0] drive_q = GAIN_ONE;
  logic [EXP_W-1:0] expo_q = EXP_ONE;
  logic [GAIN_W-1:0] makeup_q = GAIN_ONE;
  bit quiet_tail = 0;

  atan_overdrive_shaper dut (.*);

  always #2 clk = ~clk;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_tab(int i);
    longint lo[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                       33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return lo[i];
    return 64'sd1 <<< (30 - i);
  endfunction

  // shaped output for one sample under the current register values
  function automatic logic [31:0] shape_sample(logic [23:0] raw);
    bit neg;
    longint unsigned mag, u, a, m, w, sum, term, p, r;
    longint x, y, z, dx, dy, lg, t, ti, tf;
    int k;
    neg = raw[23];
    mag = neg ? (64'h1000000 - raw) : raw;
    u = mag * drive_q;
    if (u == 0) return '0;
    x = 64'sd1 <<< 39;
    y = u;
    z = 0;
    for (int i = 0; i < APPROX_STEPS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab(i);
      end else begin
        x -= dx; y += dy; z -= atan_tab(i);
      end
    end
    a = (z < 0) ? 0 : z;
    if (a == 0) return '0;
    k = 30;
    while (k > 0 && a[k] == 1'b0) k--;
    m = a << (30 - k);
    lg = 0;
    for (int j = 1; j <= LOG_FRAC; j++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        lg |= 64'sd1 <<< (LOG_FRAC - j);
      end
    end
    lg += longint'(k - 30) * (64'sd1 <<< LOG_FRAC);
    t = fshr(lg * longint'(expo_q), 16);
    ti = fshr(t, LOG_FRAC);
    tf = t - ti * (64'sd1 <<< LOG_FRAC);
    w = (longint'(tf) * 744261118) >> LOG_FRAC;
    sum = 64'd1 << 30;
    term = sum;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * w) >> 30) / n;
      if (term == 0) break;
      sum += term;
    end
    if (ti >= 0) p = (ti > 20) ? sum << 20 : sum << ti;
    else if (-ti >= 40) p = 0;
    else p = sum >> (-ti);
    r = (p >> 23) * makeup_q + (((p & 64'h7FFFFF) * makeup_q) >> 23);
    if (neg) begin
      if (r >= 64'h80000000) r = 64'h80000000;
      return 32'(64'd0 - r);
    end
    if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
    return 32'(r);
  endfunction

  // expected shaped samples, oldest first
  class shaped_board;
    logic [31:0] pending[$];
    int bad;
    function void note_sample(logic [23:0] s);
      pending.push_back(shape_sample(s));
    endfunction
    function void check_sample(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        bad++;
        if (bad <= 10) $display("unexpected output %0d", $signed(got));
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        bad++;
        if (bad <= 10)
          $display("sample_out mismatch: expected %0d got %0d", $signed(want), $signed(got));
      end
    endfunction
  endclass

  shaped_board board = new();

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_sample(in_sample_in);
    if (rst_n && out_valid && !out_stall) board.check_sample(out_sample_out);
  end

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_DRIVE:  drive_q = val[GAIN_W-1:0];
      REG_SHAPE:  expo_q = val[EXP_W-1:0];
      REG_MAKEUP: makeup_q = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // send one request, with optional idle burst first
  task automatic send_sample(logic [23:0] s, bit idle_ok);
    if (idle_ok && !quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 255)) ^ {24{$urandom_range(0, 1) == 1}};
      1: return {$urandom_range(0, 1) == 1, 23'h7FFFFF};
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [23:0] edge_vals[12] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF,
                                   24'h800000, 24'h800001, 24'h400000, 24'hC00000,
                                   24'h000100, 24'hFFFF00, 24'h555555, 24'hAAAAAA};
    logic [31:0] gains[5] = '{207, 65536, 20724305, 0, 32'h1FFFFFF};
    logic [31:0] exps[5] = '{3277, 65536, 1310720, 0, 32'h1FFFFF};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: reset settings, then extremes
    foreach (edge_vals[i]) send_sample(edge_vals[i], 0);
    drain();
    write_reg(REG_DRIVE, 20724305);
    write_reg(REG_SHAPE, 0);
    write_reg(REG_MAKEUP, 20724305);
    for (int i = 0; i < 6; i++) send_sample(edge_vals[i], 0);
    drain();
    write_reg(REG_DRIVE, 0);
    write_reg(REG_SHAPE, 1310720);
    for (int i = 0; i < 4; i++) send_sample(edge_vals[i], 0);
    drain();
    // random phases across settings
    for (int ph = 0; ph < 13; ph++) begin
      write_reg(REG_DRIVE, (ph < 10) ? gains[ph % 5] : $urandom_range(207, 20724305));
      write_reg(REG_SHAPE, (ph < 10) ? exps[(ph + 2) % 5] : $urandom_range(3277, 1310720));
      write_reg(REG_MAKEUP, (ph < 10) ? gains[(ph + 1) % 5] : $urandom_range(207, 20724305));
      if (ph == 12) quiet_tail = 1;
      repeat (150) send_sample(rand_sample(), 1);
      drain();
    end
    if (board.bad == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

[atan_overdrive_shaper.f]
rtl/aos_pkg.sv
rtl/aos_cordic.sv
rtl/aos_log2.sv
rtl/aos_pow.sv
rtl/atan_overdrive_shaper.sv
rtl/aos_checker.sv
test/atan_overdrive_shaper_tb.sv
